// ===== hw/rtl/dca_pkg.sv =====
package dca_pkg;

  localparam int SCORE_W = 16;
  localparam int COUNT_W = 21;
  localparam int DENOM_W = COUNT_W + 1;
  localparam int FRAC_W  = 16;
  localparam int DICE_W  = FRAC_W + 1;
  localparam int TOTAL_W = 25;

  // s_axis_tdata: score_background, score_foreground, truth_bit, zero fill
  localparam int IN_W  = 40;
  // m_axis_tdata: sample_dice, dice_total, empty_sample, zero fill
  localparam int OUT_W = 48;

  localparam logic [DICE_W-1:0]  DICE_ONE  = DICE_W'(1) << FRAC_W;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/dca_div.sv =====
// Restoring divider, one quotient bit per cycle.
// quot = floor(2*overlap * 2^FRAC_W / denom); needs 2*overlap <= denom.
module dca_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dca_pkg::COUNT_W-1:0]     overlap,
  input  logic [dca_pkg::DENOM_W-1:0]     denom,
  output dca_pkg::div_status_t            status,
  output logic [dca_pkg::DICE_W-1:0]      quot
);
  import dca_pkg::*;

  localparam int REM_W = DENOM_W + 1;
  localparam int CNT_W = $clog2(DICE_W);

  logic [REM_W-1:0]   rem;
  logic [DENOM_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  logic             ge;
  logic [REM_W-1:0] diff;
  logic [REM_W-1:0] rem_sel;

  always_comb begin
    ge      = rem >= {1'b0, dvs};
    diff    = rem - {1'b0, dvs};
    rem_sel = ge ? diff : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, overlap, 1'b0};
      dvs  <= denom;
      cnt  <= CNT_W'(DICE_W - 1);
      quot <= '0;
    end else if (busy) begin
      quot <= {quot[DICE_W-2:0], ge};
      // rem_sel < dvs here, so the shift cannot overflow
      rem  <= {rem_sel[REM_W-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hw/rtl/dice_coefficient_accumulator_top.sv =====
// Dice coefficient accumulator.
// Input stream s_axis: one element per beat. tdata carries the two signed
// scores and the truth label, tlast marks the last element of a sample and
// tuser the last element of the batch (looked at only with tlast).
// Output stream m_axis: one beat per sample: the sample dice (16 fraction
// bits), the running batch total and the empty flag in tdata, batch_done
// on tlast.
// Throughput: elements without tlast are taken one per cycle. A beat with
// tlast starts the serial divider, one quotient bit per cycle over 17 bits;
// the block takes no input after it until the result has been written to
// the output register in ST_PUSH, by way of ST_LOAD and ST_DIV.
// The output register lets the divider finish while the receiver stalls;
// if the previous result is still held, the new one waits and input stays
// blocked until m_axis_tready frees the register.
// Reset (rst, synchronous) clears the counters, the batch total and any
// pending result.
module dice_coefficient_accumulator_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // score_background [15:0], score_foreground [31:16], truth_bit [32]
  input  logic [dca_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tlast,
  // batch_end [0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // sample_dice [16:0], dice_total [41:17], empty_sample [42]
  output logic [dca_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast
);
  import dca_pkg::*;

  state_t state;

  logic [COUNT_W-1:0] pred_cnt;
  logic [COUNT_W-1:0] truth_cnt;
  logic [COUNT_W-1:0] ovl_cnt;
  logic [TOTAL_W-1:0] total;
  logic               batch_end;
  logic               empty;

  logic [DICE_W-1:0]  out_dice;
  logic [TOTAL_W-1:0] out_total;
  logic               out_empty;

  logic [COUNT_W-1:0] pred_cnt_next;
  logic [COUNT_W-1:0] truth_cnt_next;
  logic [COUNT_W-1:0] ovl_cnt_next;

  logic               accept;
  logic               pred;
  logic               truth;
  logic [DENOM_W-1:0] denom;
  logic               div_start;
  div_status_t        div_status;
  logic [DICE_W-1:0]  quot;
  logic [DICE_W-1:0]  dice;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_sat;
  logic               push;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pred  = $signed(s_axis_tdata[SCORE_W-1:0]) < $signed(s_axis_tdata[2*SCORE_W-1:SCORE_W]);
    truth = s_axis_tdata[2*SCORE_W];
    pred_cnt_next  = (pred && !(&pred_cnt)) ? pred_cnt + COUNT_W'(1) : pred_cnt;
    truth_cnt_next = (truth && !(&truth_cnt)) ? truth_cnt + COUNT_W'(1) : truth_cnt;
    ovl_cnt_next   = (pred && truth && !(&ovl_cnt)) ? ovl_cnt + COUNT_W'(1) : ovl_cnt;
  end

  assign denom     = DENOM_W'(pred_cnt) + DENOM_W'(truth_cnt);
  assign div_start = (state == ST_LOAD);

  dca_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .overlap (ovl_cnt),
    .denom   (denom),
    .status  (div_status),
    .quot    (quot)
  );

  always_comb begin
    if (empty)
      dice = '0;
    else if (quot > DICE_ONE)
      dice = DICE_ONE;
    else
      dice = quot;
    total_sum = (TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(dice);
    total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
  end

  assign push = (state == ST_PUSH) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pred_cnt      <= '0;
      truth_cnt     <= '0;
      ovl_cnt       <= '0;
      total         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pred_cnt  <= pred_cnt_next;
            truth_cnt <= truth_cnt_next;
            ovl_cnt   <= ovl_cnt_next;
            if (s_axis_tlast)
              state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // divider latched its operands this cycle
          pred_cnt  <= '0;
          truth_cnt <= '0;
          ovl_cnt   <= '0;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_status.done)
            state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push) begin
            total <= batch_end ? '0 : total_sat;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast)
      batch_end <= s_axis_tuser;
    if (div_start)
      empty <= (denom == '0);
    if (push) begin
      out_dice     <= dice;
      out_total    <= total_sat;
      out_empty    <= empty;
      m_axis_tlast <= batch_end;
    end
  end

  assign m_axis_tdata = {(OUT_W - DICE_W - TOTAL_W - 1)'(0), out_empty, out_total, out_dice};

endmodule
